// ===== src/sce_pkg.sv =====
package sce_pkg;

  // command codes carried in in_tuser
  localparam logic [1:0] CMD_LOAD_ENTRY = 2'd0;
  localparam logic [1:0] CMD_LOAD_RANGE = 2'd1;
  localparam logic [1:0] CMD_WRITE_SPEC = 2'd2;
  localparam logic [1:0] CMD_EVALUATE   = 2'd3;

  // fixed field widths
  localparam int unsigned COEF_W      = 18;
  localparam int unsigned SPEC_W      = 40;
  localparam int unsigned IDX_W       = 14;
  localparam int unsigned BIN_W       = 9;
  localparam int unsigned RANGE_W     = 15;
  localparam int unsigned MAG_W       = 32;
  localparam int unsigned ACC_W       = 64;
  localparam int unsigned PROD_W      = SPEC_W + COEF_W;
  localparam int unsigned COEF_FRAC   = 17;

  // stream widths
  localparam int unsigned IN_DATA_W   = 184;
  localparam int unsigned OUT_DATA_W  = 48;

  // kernel entry as stored: spectrum index and conjugated coefficient
  typedef struct packed {
    logic signed [COEF_W-1:0] coef_im;
    logic signed [COEF_W-1:0] coef_re;
    logic [IDX_W-1:0]         spec_idx;
  } kern_entry_t;

  // spectrum bin as stored
  typedef struct packed {
    logic signed [SPEC_W-1:0] im;
    logic signed [SPEC_W-1:0] re;
  } spec_entry_t;

  // bin range as stored
  typedef struct packed {
    logic [RANGE_W-1:0] stop;
    logic [RANGE_W-1:0] start;
  } bin_range_t;

endpackage

// ===== src/sce_mag.sv =====
// modulus of a complex accumulator: sum of squares on a shared 32x32
// multiplier, then a restoring integer square root, one root bit a cycle
module sce_mag (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] abs_re,
  input  logic [63:0] abs_im,
  output logic        done,
  output logic [63:0] root
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_SQ   = 2'd1;
  localparam logic [1:0] M_RT   = 2'd2;

  logic [1:0]   mstate_r;
  logic [2:0]   step_r;
  logic [5:0]   cnt_r;
  logic [63:0]  mul_r;
  logic [6:0]   shf_r;
  logic         add_en_r;
  logic [127:0] n_r;
  logic [65:0]  rem_r;
  logic [63:0]  root_r;
  logic         done_r;
  logic [63:0]  ar_r;
  logic [63:0]  ai_r;

  logic [31:0]  opa;
  logic [31:0]  opb;
  logic [6:0]   shf_nxt;
  logic [67:0]  rem_sh;
  logic [67:0]  trial;

  // operand select for the six partial products
  always_comb begin
    opa     = ar_r[31:0];
    opb     = ar_r[31:0];
    shf_nxt = 7'd0;
    unique case (step_r)
      3'd0: begin opa = ar_r[31:0];  opb = ar_r[31:0];  shf_nxt = 7'd0;  end
      3'd1: begin opa = ar_r[31:0];  opb = ar_r[63:32]; shf_nxt = 7'd33; end
      3'd2: begin opa = ar_r[63:32]; opb = ar_r[63:32]; shf_nxt = 7'd64; end
      3'd3: begin opa = ai_r[31:0];  opb = ai_r[31:0];  shf_nxt = 7'd0;  end
      3'd4: begin opa = ai_r[31:0];  opb = ai_r[63:32]; shf_nxt = 7'd33; end
      3'd5: begin opa = ai_r[63:32]; opb = ai_r[63:32]; shf_nxt = 7'd64; end
      default: begin opa = 32'd0; opb = 32'd0; shf_nxt = 7'd0; end
    endcase
  end

  // one root digit
  assign rem_sh = {rem_r, n_r[127:126]};
  assign trial  = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mstate_r <= M_IDLE;
      done_r   <= 1'b0;
      add_en_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (mstate_r)
        M_IDLE: begin
          if (start) begin
            ar_r     <= abs_re;
            ai_r     <= abs_im;
            n_r      <= '0;
            step_r   <= 3'd0;
            add_en_r <= 1'b0;
            mstate_r <= M_SQ;
          end
        end
        M_SQ: begin
          if (add_en_r) begin
            n_r <= n_r + (128'(mul_r) << shf_r);
          end
          if (step_r != 3'd6) begin
            mul_r    <= 64'(opa) * 64'(opb);
            shf_r    <= shf_nxt;
            add_en_r <= 1'b1;
            step_r   <= step_r + 3'd1;
          end else begin
            add_en_r <= 1'b0;
            rem_r    <= '0;
            root_r   <= '0;
            cnt_r    <= 6'd63;
            mstate_r <= M_RT;
          end
        end
        M_RT: begin
          if (rem_sh >= trial) begin
            rem_r  <= 66'(rem_sh - trial);
            root_r <= {root_r[62:0], 1'b1};
          end else begin
            rem_r  <= rem_sh[65:0];
            root_r <= {root_r[62:0], 1'b0};
          end
          n_r <= {n_r[125:0], 2'b00};
          if (cnt_r == 6'd0) begin
            done_r   <= 1'b1;
            mstate_r <= M_IDLE;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
        end
        default: mstate_r <= M_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== src/sparse_cqt_kernel_engine.sv =====
// write commands are accepted back to back, one per cycle
// an evaluate fetches its range, then reads each kernel entry and its spectrum
// bin (no bin read for an entry that points past the spectrum), accumulates,
// forms the squares and the root, hands the root back and loads the output
// throughput is one item at a time; a stalled result holds the next evaluate
// reset clears control and sets scale_shift to 14; memories keep their contents
module sparse_cqt_kernel_engine #(
  parameter int unsigned KERNEL_DEPTH   = 16384,
  parameter int unsigned SPECTRUM_DEPTH = 16384,
  parameter int unsigned MAX_BINS       = 512
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [4:0]   cfg_wr_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // entry_addr, spectrum_index, coef_re, coef_im, spec_re, spec_im,
  // cqt_bin, range_start, range_end, zero pad
  input  logic [183:0] in_tdata,
  // command
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_bin, magnitude, zero pad
  output logic [47:0]  out_tdata,
  // saturated
  output logic [0:0]   out_tuser
);

  localparam int unsigned KAW = $clog2(KERNEL_DEPTH);
  localparam int unsigned SAW = $clog2(SPECTRUM_DEPTH);
  localparam int unsigned BAW = $clog2(MAX_BINS);
  localparam int unsigned JW  = (KAW + 1 > 15) ? KAW + 1 : 15;
  localparam int unsigned ACC_W_L = sce_pkg::ACC_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RNG  = 4'd1;
  localparam logic [3:0] S_KRD  = 4'd2;
  localparam logic [3:0] S_KWT  = 4'd3;
  localparam logic [3:0] S_SWT  = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_MAG  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;

  // input fields
  logic [13:0]        f_entry_addr;
  logic [13:0]        f_spec_idx;
  logic signed [17:0] f_coef_re;
  logic signed [17:0] f_coef_im;
  logic signed [39:0] f_spec_re;
  logic signed [39:0] f_spec_im;
  logic [8:0]         f_bin;
  logic [14:0]        f_start;
  logic [14:0]        f_stop;

  assign f_entry_addr = in_tdata[13:0];
  assign f_spec_idx   = in_tdata[27:14];
  assign f_coef_re    = in_tdata[45:28];
  assign f_coef_im    = in_tdata[63:46];
  assign f_spec_re    = in_tdata[103:64];
  assign f_spec_im    = in_tdata[143:104];
  assign f_bin        = in_tdata[152:144];
  assign f_start      = in_tdata[167:153];
  assign f_stop       = in_tdata[182:168];

  logic [31:0] entry_ext;
  logic [31:0] spec_ext;
  logic [31:0] bin_ext;
  assign entry_ext = 32'(f_entry_addr);
  assign spec_ext  = 32'(f_spec_idx);
  assign bin_ext   = 32'(f_bin);

  // state
  logic [3:0]  state_r;
  logic [4:0]  scale_r;
  logic [8:0]  bin_r;
  logic [JW-1:0] j_r;
  logic [JW-1:0] stop_r;
  logic signed [ACC_W_L-1:0] acc_re_r;
  logic signed [ACC_W_L-1:0] acc_im_r;
  logic        ovf_r;
  logic [63:0] root_r;
  logic        mag_start;
  logic        mag_done;
  logic [63:0] mag_root;
  logic signed [sce_pkg::COEF_W-1:0] cr_r;
  logic signed [sce_pkg::COEF_W-1:0] ci_r;
  logic signed [sce_pkg::PROD_W-1:0] p_rr_r;
  logic signed [sce_pkg::PROD_W-1:0] p_ii_r;
  logic signed [sce_pkg::PROD_W-1:0] p_ri_r;
  logic signed [sce_pkg::PROD_W-1:0] p_ir_r;

  logic        out_tvalid_r;
  logic [8:0]  out_bin_r;
  logic [31:0] out_mag_r;
  logic        out_sat_r;

  // memories
  sce_pkg::kern_entry_t kern_mem [KERNEL_DEPTH];
  sce_pkg::spec_entry_t spec_mem [SPECTRUM_DEPTH];
  sce_pkg::bin_range_t  range_mem [MAX_BINS];
  sce_pkg::kern_entry_t kern_q_r;
  sce_pkg::spec_entry_t spec_q_r;
  sce_pkg::bin_range_t  range_q_r;

  logic in_xfer;
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  logic kern_we, spec_we, range_we;
  assign kern_we  = in_xfer && (in_tuser == sce_pkg::CMD_LOAD_ENTRY) &&
                    (entry_ext < KERNEL_DEPTH);
  assign range_we = in_xfer && (in_tuser == sce_pkg::CMD_LOAD_RANGE) &&
                    (bin_ext < MAX_BINS);
  assign spec_we  = in_xfer && (in_tuser == sce_pkg::CMD_WRITE_SPEC) &&
                    (spec_ext < SPECTRUM_DEPTH);

  logic kern_re, spec_re, range_re;
  logic [KAW-1:0] kern_raddr;
  logic [SAW-1:0] spec_raddr;
  logic [31:0]    kq_ext;
  logic           j_done;
  assign kq_ext     = 32'(kern_q_r.spec_idx);
  assign kern_raddr = j_r[KAW-1:0];
  assign spec_raddr = kq_ext[SAW-1:0];
  assign j_done     = (j_r >= stop_r);
  assign kern_re    = (state_r == S_KRD) && !j_done;
  assign spec_re    = (state_r == S_KWT) && (kq_ext < SPECTRUM_DEPTH);
  assign range_re   = in_xfer && (in_tuser == sce_pkg::CMD_EVALUATE);

  // kernel memory
  always_ff @(posedge clk) begin
    if (kern_we) begin
      kern_mem[entry_ext[KAW-1:0]] <= '{coef_im: f_coef_im, coef_re: f_coef_re,
                                         spec_idx: f_spec_idx};
    end
    if (kern_re) begin
      kern_q_r <= kern_mem[kern_raddr];
    end
  end

  // spectrum memory
  always_ff @(posedge clk) begin
    if (spec_we) begin
      spec_mem[spec_ext[SAW-1:0]] <= '{im: f_spec_im, re: f_spec_re};
    end
    if (spec_re) begin
      spec_q_r <= spec_mem[spec_raddr];
    end
  end

  // range memory
  always_ff @(posedge clk) begin
    if (range_we) begin
      range_mem[bin_ext[BAW-1:0]] <= '{stop: f_stop, start: f_start};
    end
    if (range_re) begin
      range_q_r <= range_mem[bin_ext[BAW-1:0]];
    end
  end

  // accumulate step with overflow detection
  logic signed [sce_pkg::PROD_W:0] t_re;
  logic signed [sce_pkg::PROD_W:0] t_im;
  logic signed [ACC_W_L:0]         sum_re;
  logic signed [ACC_W_L:0]         sum_im;
  logic                            ovf_step;
  assign t_re     = (sce_pkg::PROD_W+1)'(p_rr_r) - (sce_pkg::PROD_W+1)'(p_ii_r);
  assign t_im     = (sce_pkg::PROD_W+1)'(p_ri_r) + (sce_pkg::PROD_W+1)'(p_ir_r);
  assign sum_re   = (ACC_W_L+1)'(acc_re_r) + (ACC_W_L+1)'(t_re);
  assign sum_im   = (ACC_W_L+1)'(acc_im_r) + (ACC_W_L+1)'(t_im);
  assign ovf_step = (sum_re[ACC_W_L] != sum_re[ACC_W_L-1]) ||
                    (sum_im[ACC_W_L] != sum_im[ACC_W_L-1]);

  // range end clamped to the kernel memory
  logic [JW-1:0] stop_cl;
  assign stop_cl = (JW'(range_q_r.stop) > JW'(KERNEL_DEPTH)) ?
                   JW'(KERNEL_DEPTH) : JW'(range_q_r.stop);

  // magnitude unit
  logic [63:0] abs_re, abs_im;
  assign abs_re    = acc_re_r[ACC_W_L-1] ? 64'(-acc_re_r) : 64'(acc_re_r);
  assign abs_im    = acc_im_r[ACC_W_L-1] ? 64'(-acc_im_r) : 64'(acc_im_r);
  assign mag_start = (state_r == S_KRD) && j_done;

  sce_mag u_mag (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mag_start),
    .abs_re (abs_re),
    .abs_im (abs_im),
    .done   (mag_done),
    .root   (mag_root)
  );

  // final scaling and saturation
  logic [5:0]  shamt;
  logic [63:0] scaled;
  logic        sat_fin;
  logic        out_load;
  assign shamt    = 6'(sce_pkg::COEF_FRAC) + 6'(scale_r);
  assign scaled   = root_r >> shamt;
  assign sat_fin  = ovf_r || (scaled[63:32] != 32'd0);
  assign out_load = (state_r == S_FIN) && (!out_tvalid_r || out_tready);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 5'd14;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  // evaluation sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (range_re) begin
            bin_r    <= f_bin;
            acc_re_r <= '0;
            acc_im_r <= '0;
            ovf_r    <= 1'b0;
            root_r   <= '0;
            state_r  <= (bin_ext < MAX_BINS) ? S_RNG : S_FIN;
          end
        end
        S_RNG: begin
          j_r     <= JW'(range_q_r.start);
          stop_r  <= stop_cl;
          state_r <= S_KRD;
        end
        S_KRD: begin
          state_r <= j_done ? S_MAG : S_KWT;
        end
        S_KWT: begin
          cr_r <= kern_q_r.coef_re;
          ci_r <= kern_q_r.coef_im;
          if (kq_ext < SPECTRUM_DEPTH) begin
            state_r <= S_SWT;
          end else begin
            j_r     <= j_r + JW'(1);
            state_r <= S_KRD;
          end
        end
        S_SWT: begin
          p_rr_r  <= spec_q_r.re * cr_r;
          p_ii_r  <= spec_q_r.im * ci_r;
          p_ri_r  <= spec_q_r.re * ci_r;
          p_ir_r  <= spec_q_r.im * cr_r;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (ovf_step) begin
            ovf_r   <= 1'b1;
            state_r <= S_FIN;
          end else begin
            acc_re_r <= sum_re[ACC_W_L-1:0];
            acc_im_r <= sum_im[ACC_W_L-1:0];
            j_r      <= j_r + JW'(1);
            state_r  <= S_KRD;
          end
        end
        S_MAG: begin
          if (mag_done) begin
            root_r  <= mag_root;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bin_r <= bin_r;
      out_mag_r <= sat_fin ? 32'hFFFF_FFFF : scaled[31:0];
      out_sat_r <= sat_fin;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_mag_r, out_bin_r};
  assign out_tuser  = out_sat_r;

endmodule

// ===== src/sce_checker.sv =====
// port-level checks on the engine
module sce_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [47:0]  out_tdata,
  input logic [0:0]   out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // saturation flag goes with an all-ones magnitude
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[40:9] == 32'hFFFF_FFFF)
    else $error("saturated result without full-scale magnitude");

  // reset empties the output
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a write command transfer produces no result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != sce_pkg::CMD_EVALUATE) && !out_tvalid
    |=> !out_tvalid)
    else $error("result after a write command");

endmodule

bind sparse_cqt_kernel_engine sce_checker u_sce_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
